>>> sv/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// shared widths, register indexes, result codes and distance helpers for the
// distance cull dense packer
// ----------------------------------------------------------------------------
`default_nettype none

package dcp_pkg;

    localparam int MAX_TRIANGLES_DEF = 4096;

    localparam int COORD_W     = 24;
    localparam int DIST_IN_W   = 24;
    localparam int ID_W        = 12;
    localparam int COUNT_OUT_W = 13;
    localparam int ACTION_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int MAG_W       = COORD_W + 1;
    localparam int SQ_W        = 2 * MAG_W;

    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_DIST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOP_DIST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_ENABLE = 3'd5;

    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    typedef struct packed {
        logic far;
        logic near;
    } dist_flags_t;

    function automatic logic [MAG_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic [MAG_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[MAG_W-1] ? MAG_W'(~d + MAG_W'(1)) : d;
    endfunction

endpackage

`default_nettype wire

>>> sv/dcp_if.sv
// ----------------------------------------------------------------------------
// dcp interfaces
// query, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dcp_query_if;
    import dcp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ID_W-1:0]            triangle_id;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_z;

    modport source (output valid, triangle_id, center_x, center_y, center_z,
                    input ready);
    modport sink   (input valid, triangle_id, center_x, center_y, center_z,
                    output ready);
endinterface

interface dcp_result_if;
    import dcp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic                       write_valid;
    logic [ID_W-1:0]            write_slot;
    logic [ID_W-1:0]            source_triangle;
    logic [COUNT_OUT_W-1:0]     visible_count;

    modport source (output valid, action, write_valid, write_slot, source_triangle,
                    visible_count, input ready);
    modport sink   (input valid, action, write_valid, write_slot, source_triangle,
                    visible_count, output ready);
endinterface

interface dcp_cfg_if;
    import dcp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CFG_IDX_W-1:0]       index;
    logic [CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/dcp_dist.sv
// ----------------------------------------------------------------------------
// dcp_dist
// squared viewer distance of one item and the add / remove thresholds,
// three register stages: magnitude, squares, sum
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_dist (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic signed [dcp_pkg::COORD_W-1:0] center_x,
    input  wire logic signed [dcp_pkg::COORD_W-1:0] center_y,
    input  wire logic signed [dcp_pkg::COORD_W-1:0] center_z,
    input  wire logic signed [dcp_pkg::COORD_W-1:0] viewer_x,
    input  wire logic signed [dcp_pkg::COORD_W-1:0] viewer_y,
    input  wire logic signed [dcp_pkg::COORD_W-1:0] viewer_z,
    input  wire logic [dcp_pkg::DIST_IN_W-1:0]      add_distance,
    input  wire logic [dcp_pkg::DIST_IN_W-1:0]      slop_distance,
    output dcp_pkg::dist_flags_t                    flags
);
    import dcp_pkg::*;

    logic [MAG_W-1:0] mag_x_reg;
    logic [MAG_W-1:0] mag_y_reg;
    logic [MAG_W-1:0] mag_z_reg;
    logic [SQ_W-1:0]  sq_x_reg;
    logic [SQ_W-1:0]  sq_y_reg;
    logic [SQ_W-1:0]  sq_z_reg;
    logic [SQ_W-1:0]  dist2_reg;
    logic [MAG_W-1:0] rsum_reg;
    logic [SQ_W-1:0]  add2_reg;
    logic [SQ_W-1:0]  remove2_reg;
    logic             prim_reg;

    // startup marker only, datapath registers carry no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_reg <= 1'b0;
        end
        else
        begin
            prim_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_x_reg <= abs_diff(center_x, viewer_x);
            mag_y_reg <= abs_diff(center_y, viewer_y);
            mag_z_reg <= abs_diff(center_z, viewer_z);
        end
        sq_x_reg    <= SQ_W'(mag_x_reg) * SQ_W'(mag_x_reg);
        sq_y_reg    <= SQ_W'(mag_y_reg) * SQ_W'(mag_y_reg);
        sq_z_reg    <= SQ_W'(mag_z_reg) * SQ_W'(mag_z_reg);
        dist2_reg   <= sq_x_reg + sq_y_reg + sq_z_reg;
        rsum_reg    <= MAG_W'(add_distance) + MAG_W'(slop_distance);
        add2_reg    <= SQ_W'(add_distance) * SQ_W'(add_distance);
        remove2_reg <= SQ_W'(rsum_reg) * SQ_W'(rsum_reg);
    end

    assign flags.far  = prim_reg && (dist2_reg > remove2_reg);
    assign flags.near = prim_reg && (dist2_reg < add2_reg);

endmodule

`default_nettype wire

>>> sv/distance_cull_dense_packer.sv
// ----------------------------------------------------------------------------
// distance_cull_dense_packer
// distance culling over a densely packed visible set, swap-remove on delete
// ----------------------------------------------------------------------------
// result: registered in S_DEC once the result register is free, after
//   S_SQ and S_SUM; one item at a time, taken in S_IDLE, plus S_FIX when
//   a delete moves the last entry (second slot map write, single port)
// reset: configuration to defaults, then a clearing pass fills both maps
//   with identity before the first item is taken
`default_nettype none

module distance_cull_dense_packer #(
    parameter int MAX_TRIANGLES = dcp_pkg::MAX_TRIANGLES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    dcp_query_if.sink       query,
    dcp_result_if.source    result,
    dcp_cfg_if.sink         cfg
);
    import dcp_pkg::*;

    localparam int SLOT_W = $clog2(MAX_TRIANGLES);
    localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
    localparam int CMP_W  = (CNT_W > ID_W) ? CNT_W : ID_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SQ    = 6'b000100,
        S_SUM   = 6'b001000,
        S_DEC   = 6'b010000,
        S_FIX   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [COORD_W-1:0] viewer_x_reg;
    logic signed [COORD_W-1:0] viewer_y_reg;
    logic signed [COORD_W-1:0] viewer_z_reg;
    logic [DIST_IN_W-1:0]      add_dist_reg;
    logic [DIST_IN_W-1:0]      slop_dist_reg;
    logic                      cull_en_reg;

    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] id_reg;
    logic              id_ok_reg;

    logic [SLOT_W:0]   slot_mem [MAX_TRIANGLES];
    logic [SLOT_W-1:0] dense_mem [MAX_TRIANGLES];
    logic [SLOT_W:0]   slot_rd_reg;
    logic [SLOT_W-1:0] dense_rd_reg;

    logic              slot_we;
    logic [SLOT_W-1:0] slot_wa;
    logic [SLOT_W:0]   slot_wd;
    logic [SLOT_W-1:0] slot_ra;
    logic              dense_we;
    logic [SLOT_W-1:0] dense_wa;
    logic [SLOT_W-1:0] dense_wd;
    logic [SLOT_W-1:0] dense_ra;

    logic              out_valid_reg;
    logic [ACTION_W-1:0] act_reg;
    logic              wv_reg;
    logic [ID_W-1:0]   wslot_reg;
    logic [ID_W-1:0]   src_reg;
    logic [COUNT_OUT_W-1:0] vcount_reg;

    logic              accept;
    logic              cfg_we;
    logic              in_range;
    logic              vis;
    logic [SLOT_W-1:0] to_slot;
    logic [SLOT_W-1:0] last_slot;
    logic [SLOT_W-1:0] count_slot;
    logic              out_free;
    logic              dec_go;
    logic              do_ins;
    logic              do_del;
    logic              do_move;
    dist_flags_t       flags;

    assign accept   = query.valid && query.ready;
    assign cfg_we   = cfg.valid && cfg.ready;
    assign in_range = CMP_W'(query.triangle_id) < CMP_W'(MAX_TRIANGLES);

    assign query.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viewer_x_reg  <= '0;
            viewer_y_reg  <= '0;
            viewer_z_reg  <= '0;
            add_dist_reg  <= '0;
            slop_dist_reg <= '0;
            cull_en_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg.index)
                REG_VIEWER_X:    viewer_x_reg  <= cfg.data;
                REG_VIEWER_Y:    viewer_y_reg  <= cfg.data;
                REG_VIEWER_Z:    viewer_z_reg  <= cfg.data;
                REG_ADD_DIST:    add_dist_reg  <= cfg.data;
                REG_SLOP_DIST:   slop_dist_reg <= cfg.data;
                REG_CULL_ENABLE: cull_en_reg   <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    dcp_dist u_dist (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .center_x      (query.center_x),
        .center_y      (query.center_y),
        .center_z      (query.center_z),
        .viewer_x      (viewer_x_reg),
        .viewer_y      (viewer_y_reg),
        .viewer_z      (viewer_z_reg),
        .add_distance  (add_dist_reg),
        .slop_distance (slop_dist_reg),
        .flags         (flags)
    );

    // slot map entry: visible bit over packed slot
    assign vis        = slot_rd_reg[SLOT_W];
    assign to_slot    = slot_rd_reg[SLOT_W-1:0];
    assign last_slot  = SLOT_W'(count_reg - CNT_W'(1));
    assign count_slot = SLOT_W'(count_reg);
    assign out_free   = !out_valid_reg || result.ready;
    assign dec_go     = (state_reg == S_DEC) && out_free;
    assign do_del     = dec_go && id_ok_reg && vis && flags.far && (count_reg != '0);
    assign do_ins     = dec_go && id_ok_reg && !vis && flags.near
                        && (count_reg != CNT_W'(MAX_TRIANGLES));
    assign do_move    = do_del && (to_slot != last_slot);

    assign slot_ra  = in_range ? SLOT_W'(query.triangle_id) : '0;
    assign dense_ra = (count_reg == '0) ? '0 : last_slot;

    always_comb
    begin
        slot_we  = 1'b0;
        slot_wa  = '0;
        slot_wd  = '0;
        dense_we = 1'b0;
        dense_wa = '0;
        dense_wd = '0;
        if (state_reg == S_CLEAR)
        begin
            slot_we  = 1'b1;
            slot_wa  = clr_reg;
            slot_wd  = {1'b1, clr_reg};
            dense_we = 1'b1;
            dense_wa = clr_reg;
            dense_wd = clr_reg;
        end
        else if (do_ins)
        begin
            slot_we  = 1'b1;
            slot_wa  = id_reg;
            slot_wd  = {1'b1, count_slot};
            dense_we = 1'b1;
            dense_wa = count_slot;
            dense_wd = id_reg;
        end
        else if (do_del)
        begin
            slot_we  = 1'b1;
            slot_wa  = id_reg;
            slot_wd  = {1'b0, to_slot};
            dense_we = do_move;
            dense_wa = to_slot;
            dense_wd = dense_rd_reg;
        end
        else if (state_reg == S_FIX)
        begin
            // moved triangle now lives in the freed slot
            slot_we  = 1'b1;
            slot_wa  = dense_rd_reg;
            slot_wd  = {1'b1, to_slot};
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (accept)
        begin
            slot_rd_reg <= slot_mem[slot_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dense_we)
        begin
            dense_mem[dense_wa] <= dense_wd;
        end
        if (state_reg == S_SQ)
        begin
            dense_rd_reg <= dense_mem[dense_ra];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(MAX_TRIANGLES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:    state_next = S_SUM;
            S_SUM:   state_next = S_DEC;
            S_DEC:
            begin
                if (out_free)
                begin
                    state_next = do_move ? S_FIX : S_IDLE;
                end
                if (do_ins)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (do_del)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_FIX:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= CNT_W'(MAX_TRIANGLES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            if (dec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg    <= slot_ra;
            id_ok_reg <= cull_en_reg && in_range;
        end
        if (dec_go)
        begin
            vcount_reg <= COUNT_OUT_W'(count_next);
            if (do_ins)
            begin
                act_reg   <= ACT_INSERT;
                wv_reg    <= 1'b1;
                wslot_reg <= ID_W'(count_slot);
                src_reg   <= ID_W'(id_reg);
            end
            else if (do_del)
            begin
                act_reg   <= ACT_DELETE;
                wv_reg    <= do_move;
                wslot_reg <= do_move ? ID_W'(to_slot) : '0;
                src_reg   <= do_move ? ID_W'(dense_rd_reg) : '0;
            end
            else
            begin
                act_reg   <= ACT_NONE;
                wv_reg    <= 1'b0;
                wslot_reg <= '0;
                src_reg   <= '0;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.action          = act_reg;
    assign result.write_valid     = wv_reg;
    assign result.write_slot      = wslot_reg;
    assign result.source_triangle = src_reg;
    assign result.visible_count   = vcount_reg;

endmodule

`default_nettype wire

>>> tb/sv/tb_distance_cull_dense_packer.sv
// ----------------------------------------------------------------------------
// tb_distance_cull_dense_packer
// drives triangle queries through the distance cull dense packer and checks
// each result against an in-bench model of the packed visible set: squared
// distance against the insert and remove radii, append on insert, swap of the
// last entry on delete. directed edge cases first, then random traffic over
// several viewer and radius settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_distance_cull_dense_packer;
    import dcp_pkg::*;

    localparam int MAX_TRI = MAX_TRIANGLES_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic                   write_valid;
        logic [ID_W-1:0]        write_slot;
        logic [ID_W-1:0]        source_triangle;
        logic [COUNT_OUT_W-1:0] visible_count;
    } cull_result_t;

    logic clk = 1'b0;
    logic rst_n;

    dcp_query_if  query_ch ();
    dcp_result_if result_ch ();
    dcp_cfg_if    cfg_ch ();

    distance_cull_dense_packer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // model state
    logic signed [COORD_W-1:0]  viewer_pos [3];
    logic [DIST_IN_W-1:0]       add_dist;
    logic [DIST_IN_W-1:0]       slop_dist;
    logic                       cull_on;
    logic [COUNT_OUT_W-1:0]     slot_map [MAX_TRI];
    logic [ID_W-1:0]            tri_map [MAX_TRI];
    bit                         shown [MAX_TRI];
    int                         packed_cnt;

    cull_result_t pending_results [$];
    logic [ID_W-1:0] dropped_ids [$];
    cull_result_t seen_res;
    cull_result_t want_res;

    bit gaps_on = 1'b1;
    int stall_left = 0;
    int fail_count = 0;
    int n_items = 0;
    int n_inserted = 0;
    int n_deleted = 0;
    int n_moved = 0;
    int min_cnt = MAX_TRI;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_distance_cull_dense_packer: FAIL");
        $finish;
    end

    function automatic logic [63:0] sq_gap(logic signed [COORD_W-1:0] c,
                                           logic signed [COORD_W-1:0] v);
        logic signed [COORD_W+1:0] d;
        logic [COORD_W+1:0] m;
        d = c;
        d = d - v;
        m = (d < 0) ? -d : d;
        return 64'(m) * 64'(m);
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < MAX_TRI; i++)
        begin
            slot_map[i] = COUNT_OUT_W'(i);
            tri_map[i]  = ID_W'(i);
            shown[i]    = 1'b1;
        end
        packed_cnt = MAX_TRI;
        for (int k = 0; k < 3; k++)
            viewer_pos[k] = '0;
        add_dist  = '0;
        slop_dist = '0;
        cull_on   = 1'b1;
    endfunction

    function automatic cull_result_t cull_predict(logic [ID_W-1:0] id,
                                                  logic signed [COORD_W-1:0] cx,
                                                  logic signed [COORD_W-1:0] cy,
                                                  logic signed [COORD_W-1:0] cz);
        cull_result_t res;
        logic [63:0] dist2;
        logic [63:0] add2;
        logic [63:0] rsum;
        logic [63:0] remove2;
        int last;
        int to;
        int mover;
        res = '0;
        if (cull_on && int'(id) < MAX_TRI)
        begin
            dist2 = sq_gap(cx, viewer_pos[0]) + sq_gap(cy, viewer_pos[1])
                  + sq_gap(cz, viewer_pos[2]);
            add2    = 64'(add_dist) * 64'(add_dist);
            rsum    = 64'(add_dist) + 64'(slop_dist);
            remove2 = rsum * rsum;
            if (shown[id])
            begin
                if (dist2 > remove2 && packed_cnt > 0)
                begin
                    last = packed_cnt - 1;
                    to   = int'(slot_map[id]);
                    res.action = ACT_DELETE;
                    shown[id] = 1'b0;
                    n_deleted++;
                    dropped_ids.insert(dropped_ids.size(), id);
                    if (dropped_ids.size() > 256)
                        void'(dropped_ids.pop_front());
                    if (to != last)
                    begin
                        mover = int'(tri_map[last]);
                        slot_map[mover] = COUNT_OUT_W'(to);
                        tri_map[to] = ID_W'(mover);
                        res.write_valid     = 1'b1;
                        res.write_slot      = ID_W'(to);
                        res.source_triangle = ID_W'(mover);
                        n_moved++;
                    end
                    packed_cnt = last;
                end
            end
            else if (dist2 < add2 && packed_cnt < MAX_TRI)
            begin
                slot_map[id] = COUNT_OUT_W'(packed_cnt);
                tri_map[packed_cnt] = id;
                shown[id] = 1'b1;
                res.action          = ACT_INSERT;
                res.write_valid     = 1'b1;
                res.write_slot      = ID_W'(packed_cnt);
                res.source_triangle = id;
                packed_cnt++;
                n_inserted++;
            end
        end
        res.visible_count = COUNT_OUT_W'(packed_cnt);
        if (packed_cnt < min_cnt)
            min_cnt = packed_cnt;
        return res;
    endfunction

    function automatic int src_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // result side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            if (gaps_on && $urandom_range(0, 99) < 25)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen_res = '{result_ch.action, result_ch.write_valid, result_ch.write_slot,
                         result_ch.source_triangle, result_ch.visible_count};
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result act=%0d wv=%0d slot=%0d src=%0d cnt=%0d",
                         $time, seen_res.action, seen_res.write_valid, seen_res.write_slot,
                         seen_res.source_triangle, seen_res.visible_count);
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (seen_res !== want_res)
                begin
                    fail_count++;
                    $display({"%0t: mismatch expected act=%0d wv=%0d slot=%0d src=%0d ",
                              "cnt=%0d, actual act=%0d wv=%0d slot=%0d src=%0d cnt=%0d"},
                             $time, want_res.action, want_res.write_valid,
                             want_res.write_slot, want_res.source_triangle,
                             want_res.visible_count, seen_res.action,
                             seen_res.write_valid, seen_res.write_slot,
                             seen_res.source_triangle, seen_res.visible_count);
                end
            end
        end
    end

    task automatic send_item(input logic [ID_W-1:0] id,
                             input logic signed [COORD_W-1:0] cx,
                             input logic signed [COORD_W-1:0] cy,
                             input logic signed [COORD_W-1:0] cz);
        int gap;
        gap = src_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            query_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        query_ch.valid       <= 1'b1;
        query_ch.triangle_id <= id;
        query_ch.center_x    <= cx;
        query_ch.center_y    <= cy;
        query_ch.center_z    <= cz;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), cull_predict(id, cx, cy, cz));
        n_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_VIEWER_X:    viewer_pos[0] = value;
            REG_VIEWER_Y:    viewer_pos[1] = value;
            REG_VIEWER_Z:    viewer_pos[2] = value;
            REG_ADD_DIST:    add_dist = value;
            REG_SLOP_DIST:   slop_dist = value;
            REG_CULL_ENABLE: cull_on = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // let every queued item come back before touching the registers
    task automatic drain();
        @(negedge clk);
        query_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_item(ID_W'(0), 24'sd0, 24'sd0, 24'sd0);
        send_item(ID_W'(4095), 24'sd1, 24'sd0, 24'sd0);
        send_item(ID_W'(0), 24'sd0, 24'sd0, -24'sd1);
        send_item(ID_W'(0), 24'sd0, 24'sd0, 24'sd0);
    endtask

    task automatic test_cull_disabled();
        drain();
        write_reg(REG_CULL_ENABLE, 24'hFFFFFE);
        send_item(ID_W'(7), 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        send_item(ID_W'(4095), 24'sd0, 24'sd0, 24'sd0);
    endtask

    task automatic test_coordinate_extremes();
        drain();
        write_reg(REG_VIEWER_X, 24'h800000);
        write_reg(REG_VIEWER_Y, 24'h7FFFFF);
        write_reg(REG_VIEWER_Z, 24'h800000);
        write_reg(REG_ADD_DIST, 24'hFFFFFF);
        write_reg(REG_SLOP_DIST, 24'hFFFFFF);
        write_reg(REG_CULL_ENABLE, 24'h5A5A5B);
        send_item(ID_W'(0), 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        send_item(ID_W'(0), 24'sh800000, 24'sh7FFFFF, 24'sh800000);
        send_item(ID_W'(0), 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        send_item(ID_W'(4095), 24'sh800000, 24'sh7FFFFF, 24'sh800000);
        drain();
        write_reg(REG_SLOP_DIST, 24'h000000);
        send_item(ID_W'(0), 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    endtask

    // exact equality with either radius must leave the set alone
    task automatic test_threshold_edges();
        drain();
        write_reg(REG_VIEWER_X, 24'd256);
        write_reg(REG_VIEWER_Y, -24'sd512);
        write_reg(REG_VIEWER_Z, 24'd1024);
        write_reg(REG_ADD_DIST, 24'd256);
        write_reg(REG_SLOP_DIST, 24'd128);
        send_item(ID_W'(5), 24'sd640, -24'sd512, 24'sd1024);
        send_item(ID_W'(5), 24'sd641, -24'sd512, 24'sd1024);
        send_item(ID_W'(5), 24'sd256, -24'sd768, 24'sd1024);
        send_item(ID_W'(5), 24'sd256, -24'sd767, 24'sd1024);
        send_item(ID_W'(9), 24'sd256, -24'sd512, 24'sd1409);
        send_item(ID_W'(9), 24'sd256, -24'sd512, 24'sd1024);
    endtask

    task automatic test_unused_register();
        drain();
        write_reg(REG_UNUSED_LO, CFG_DATA_W'($urandom));
        write_reg(REG_UNUSED_HI, CFG_DATA_W'($urandom));
        send_item(ID_W'(9), 24'sd256, -24'sd512, 24'sd1409);
    endtask

    task automatic random_item();
        logic [ID_W-1:0] id;
        logic signed [COORD_W-1:0] c [3];
        int off [3];
        int r;
        int mode;
        int ax;
        int rsum;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            r = $urandom_range(0, 31);
            id = (r < 16) ? ID_W'(r) : ID_W'(4064 + r);
        end
        else if (r < 65 && dropped_ids.size() > 0)
            id = dropped_ids[$urandom_range(0, dropped_ids.size() - 1)];
        else
            id = ID_W'($urandom);
        rsum = int'(add_dist) + int'(slop_dist);
        ax = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
            off[k] = 0;
        mode = $urandom_range(0, 99);
        if (mode < 30)
        begin
            for (int k = 0; k < 3; k++)
                off[k] = int'($urandom_range(0, add_dist)) - int'(add_dist / 2);
        end
        else if (mode < 45)
            off[ax] = int'(add_dist) + int'($urandom_range(0, slop_dist));
        else if (mode < 75)
        begin
            for (int k = 0; k < 3; k++)
                off[k] = int'($urandom_range(0, 255)) - 128;
            off[ax] = rsum + int'($urandom_range(1, 4096));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: off[ax] = int'(add_dist) - 1;
                1: off[ax] = int'(add_dist);
                2: off[ax] = rsum;
                default: off[ax] = rsum + 1;
            endcase
        end
        if ($urandom_range(0, 1))
            off[ax] = -off[ax];
        for (int k = 0; k < 3; k++)
        begin
            if (mode >= 90)
                c[k] = COORD_W'($urandom);
            else
                c[k] = COORD_W'(int'(viewer_pos[k]) + off[k]);
        end
        send_item(id, c[0], c[1], c[2]);
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] vx;
        logic [CFG_DATA_W-1:0] vy;
        logic [CFG_DATA_W-1:0] vz;
        logic [CFG_DATA_W-1:0] add_v;
        logic [CFG_DATA_W-1:0] slop_v;
        logic cull_v;
        int n;
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            vx = CFG_DATA_W'($urandom);
            vy = CFG_DATA_W'($urandom);
            vz = CFG_DATA_W'($urandom);
            add_v  = CFG_DATA_W'($urandom_range(0, 1 << 22));
            slop_v = CFG_DATA_W'($urandom_range(0, 1 << 20));
            cull_v = 1'b1;
            n = 320;
            case (phase)
                0:
                begin
                    vx = CFG_DATA_W'($urandom_range(0, 131071)) - CFG_DATA_W'(65536);
                    vy = CFG_DATA_W'($urandom_range(0, 131071)) - CFG_DATA_W'(65536);
                    vz = CFG_DATA_W'($urandom_range(0, 131071)) - CFG_DATA_W'(65536);
                    add_v  = CFG_DATA_W'($urandom_range(0, 65535));
                    slop_v = CFG_DATA_W'($urandom_range(0, 4095));
                end
                2:
                begin
                    add_v  = 24'hFFFFFF;
                    slop_v = 24'hFFFFFF;
                end
                3:
                begin
                    vx = 24'h800000;
                    vy = 24'h7FFFFF;
                    add_v  = '0;
                    slop_v = '0;
                end
                4:
                begin
                    cull_v = 1'b0;
                    n = 60;
                end
                5:
                begin
                    add_v  = CFG_DATA_W'($urandom_range(1, 1 << 18));
                    slop_v = '0;
                end
                default: ;
            endcase
            write_reg(REG_VIEWER_X, vx);
            write_reg(REG_VIEWER_Y, vy);
            write_reg(REG_VIEWER_Z, vz);
            write_reg(REG_ADD_DIST, add_v);
            write_reg(REG_SLOP_DIST, slop_v);
            write_reg(REG_CULL_ENABLE, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1))
                                       | CFG_DATA_W'(cull_v));
            // one phase runs back to back with no gaps on either side
            gaps_on = (phase != 1);
            repeat (n) random_item();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        query_ch.valid       = 1'b0;
        query_ch.triangle_id = '0;
        query_ch.center_x    = '0;
        query_ch.center_y    = '0;
        query_ch.center_z    = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        result_ch.ready      = 1'b0;
        model_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_cull_disabled();
        test_coordinate_extremes();
        test_threshold_edges();
        test_unused_register();
        test_random_traffic();

        drain();
        repeat (10) @(posedge clk);
        $display("checked %0d items: %0d inserts, %0d deletes, %0d moves of the last entry",
                 n_items, n_inserted, n_deleted, n_moved);
        $display("visible set went as low as %0d of %0d, %0d mismatches",
                 min_cnt, MAX_TRI, fail_count);
        if (fail_count == 0)
            $display("tb_distance_cull_dense_packer: PASS");
        else
            $display("tb_distance_cull_dense_packer: FAIL");
        $finish;
    end

endmodule
